/* hw/rtl/dmc_pkg.sv */
`default_nettype none

package dmc_pkg;

  localparam int unsigned TickW = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [TickW-1:0] TickMax = '1;

  // Register indexes on the configuration port
  typedef enum logic [CfgIndexW-1:0] {
    REG_STUCK_CHECK    = 2'd0,
    REG_TRAVEL_TIMEOUT = 2'd1,
    REG_PAUSE_TIMEOUT  = 2'd2
  } reg_index_t;

  localparam logic [CfgDataW-1:0] StuckCheckReset    = 8'd7;
  localparam logic [CfgDataW-1:0] TravelTimeoutReset = 8'd25;
  localparam logic [CfgDataW-1:0] PauseTimeoutReset  = 8'd80;

  typedef enum logic [3:0] {
    MODE_CLOSED      = 4'd0,
    MODE_OPENING     = 4'd1,
    MODE_OPEN        = 4'd2,
    MODE_CLOSING     = 4'd3,
    MODE_PAUSE_OPEN  = 4'd4,
    MODE_PAUSE_CLOSE = 4'd5,
    MODE_STOPPED     = 4'd6,
    MODE_ERROR       = 4'd7,
    MODE_START       = 4'd8
  } mode_t;

  typedef enum logic [2:0] {
    STAT_CLOSED  = 3'd0,
    STAT_OPENING = 3'd1,
    STAT_OPEN    = 3'd2,
    STAT_CLOSING = 3'd3,
    STAT_STOPPED = 3'd4,
    STAT_ERROR   = 3'd5
  } status_t;

  typedef struct packed {
    logic [TickW-1:0] stuck_check_ticks;
    logic [TickW-1:0] travel_timeout_ticks;
    logic [TickW-1:0] pause_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t            mode;
    logic [TickW-1:0] tick_count;
    logic             green_lamp;
    logic             red_lamp;
    logic             button_prev;
  } ctrl_state_t;

  typedef struct packed {
    logic button_level;
    logic closed_sensor;
    logic open_sensor;
    logic tick;
    logic status_query;
  } sample_t;

  typedef struct packed {
    logic    motor_run;
    logic    green_led;
    logic    red_led;
    mode_t   door_state;
    logic    status_valid;
    status_t status_code;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/dmc_in_if.sv */
`default_nettype none

interface dmc_in_if;
  logic valid;
  logic ready;
  logic button_level;
  logic closed_sensor;
  logic open_sensor;
  logic tick;
  logic status_query;

  modport source (
    output valid, button_level, closed_sensor, open_sensor, tick, status_query,
    input  ready
  );

  modport sink (
    input  valid, button_level, closed_sensor, open_sensor, tick, status_query,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/dmc_out_if.sv */
`default_nettype none

interface dmc_out_if;
  logic       valid;
  logic       ready;
  logic       motor_run;
  logic       green_led;
  logic       red_led;
  logic [3:0] door_state;
  logic       status_valid;
  logic [2:0] status_code;

  modport source (
    output valid, motor_run, green_led, red_led, door_state, status_valid, status_code,
    input  ready
  );

  modport sink (
    input  valid, motor_run, green_led, red_led, door_state, status_valid, status_code,
    output ready
  );
endinterface

`default_nettype wire

/* hw/rtl/door_motor_controller.sv */
// Channel   Dir  Handshake      Word
// sample    in   valid/ready    button_level, closed_sensor, open_sensor, tick, status_query
// result    out  valid/ready    motor_run, green_led, red_led, door_state,
//                               status_valid, status_code
// cfg       in   cfg_we         cfg_index (0 stuck, 1 travel, 2 pause), cfg_data
//
// One word per clock while the result side is not stalled. A sample is captured
// in the input register, then one pass of the step logic updates the door state
// and loads the result register once that register is free to take it.
// The door state register feeds straight back into the step logic, so
// back-to-back samples see each other's updates.
// Reset (rst, synchronous) puts the door in start mode with cleared counters and
// restores the timeout registers. A stalled result holds both stages; the input
// takes a new word whenever the input register is empty or moving on.

`default_nettype none

module door_motor_controller (
  input  wire logic                           clk,
  input  wire logic                           rst,
  dmc_in_if.sink                              sample,
  dmc_out_if.source                           result,
  input  wire logic                           cfg_we,
  input  wire logic [dmc_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [dmc_pkg::CfgDataW-1:0]   cfg_data
);
  import dmc_pkg::*;

  cfg_t        cfg;
  ctrl_state_t state;
  ctrl_state_t state_next;
  result_t     step_res;

  // Input register
  logic    in_valid;
  sample_t in_word;

  // Result register
  logic    out_valid;
  result_t out_word;

  logic out_free;
  logic advance;

  assign out_free = ~out_valid | result.ready;
  assign advance  = in_valid & out_free;

  assign sample.ready = ~in_valid | out_free;

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stuck_check_ticks    <= StuckCheckReset;
      cfg.travel_timeout_ticks <= TravelTimeoutReset;
      cfg.pause_timeout_ticks  <= PauseTimeoutReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_STUCK_CHECK:    cfg.stuck_check_ticks    <= cfg_data;
        REG_TRAVEL_TIMEOUT: cfg.travel_timeout_ticks <= cfg_data;
        REG_PAUSE_TIMEOUT:  cfg.pause_timeout_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the sample word
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      in_word.button_level  <= sample.button_level;
      in_word.closed_sensor <= sample.closed_sensor;
      in_word.open_sensor   <= sample.open_sensor;
      in_word.tick          <= sample.tick;
      in_word.status_query  <= sample.status_query;
    end
  end

  dmc_step u_step (
    .cfg (cfg),
    .cur (state),
    .smp (in_word),
    .nxt (state_next),
    .res (step_res)
  );

  // Door state advances only when the word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= MODE_START;
      state.tick_count  <= '0;
      state.green_lamp  <= 1'b0;
      state.red_lamp    <= 1'b0;
      state.button_prev <= 1'b1;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= step_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.motor_run    = out_word.motor_run;
  assign result.green_led    = out_word.green_led;
  assign result.red_led      = out_word.red_led;
  assign result.door_state   = out_word.door_state;
  assign result.status_valid = out_word.status_valid;
  assign result.status_code  = out_word.status_code;

endmodule

`default_nettype wire

/* hw/rtl/dmc_step.sv */
`default_nettype none

module dmc_step (
  input  dmc_pkg::cfg_t        cfg,
  input  dmc_pkg::ctrl_state_t cur,
  input  dmc_pkg::sample_t     smp,
  output dmc_pkg::ctrl_state_t nxt,
  output dmc_pkg::result_t     res
);
  import dmc_pkg::*;

  logic             press;
  logic             closed_act;
  logic             open_act;
  logic [TickW-1:0] cnt;
  logic             go;
  mode_t            target;
  logic             status_valid;
  status_t          status_code;

  assign press      = cur.button_prev & ~smp.button_level;
  assign closed_act = ~smp.closed_sensor;
  assign open_act   = ~smp.open_sensor;

  // Status reply reflects the mode held on arrival
  always_comb begin
    status_valid = smp.status_query;
    status_code  = STAT_CLOSED;
    case (cur.mode)
      MODE_CLOSED:      status_code = STAT_CLOSED;
      MODE_OPENING:     status_code = STAT_OPENING;
      MODE_OPEN:        status_code = STAT_OPEN;
      MODE_CLOSING:     status_code = STAT_CLOSING;
      MODE_PAUSE_OPEN:  status_code = STAT_STOPPED;
      MODE_PAUSE_CLOSE: status_code = STAT_STOPPED;
      MODE_STOPPED:     status_code = STAT_STOPPED;
      MODE_ERROR:       status_code = STAT_ERROR;
      default:          status_valid = 1'b0;
    endcase
  end

  // Transition rule, judged on the tick count after this sample's tick
  always_comb begin
    cnt = cur.tick_count;
    if (smp.tick && (cur.tick_count != TickMax)) begin
      cnt = cur.tick_count + TickW'(1);
    end
    go     = 1'b0;
    target = MODE_START;
    case (cur.mode)
      MODE_CLOSED: begin
        go     = press;
        target = MODE_OPENING;
      end
      MODE_OPENING: begin
        go = 1'b1;
        if (press) begin
          target = MODE_PAUSE_OPEN;
        end else if (open_act) begin
          target = MODE_OPEN;
        end else if (cnt >= cfg.travel_timeout_ticks) begin
          target = MODE_ERROR;
        end else if ((cnt > cfg.stuck_check_ticks) && closed_act) begin
          target = MODE_ERROR;
        end else begin
          go = 1'b0;
        end
      end
      MODE_OPEN: begin
        go     = press || (cnt >= cfg.pause_timeout_ticks);
        target = MODE_CLOSING;
      end
      MODE_CLOSING: begin
        go = 1'b1;
        if (press) begin
          target = MODE_PAUSE_CLOSE;
        end else if (closed_act) begin
          target = MODE_CLOSED;
        end else if (cnt >= cfg.travel_timeout_ticks) begin
          target = MODE_ERROR;
        end else if ((cnt > cfg.stuck_check_ticks) && open_act) begin
          target = MODE_ERROR;
        end else begin
          go = 1'b0;
        end
      end
      MODE_PAUSE_OPEN: begin
        go     = press || (cnt >= cfg.pause_timeout_ticks);
        target = press ? MODE_STOPPED : MODE_CLOSING;
      end
      MODE_PAUSE_CLOSE: begin
        go     = press || (cnt >= cfg.pause_timeout_ticks);
        target = press ? MODE_STOPPED : MODE_OPENING;
      end
      MODE_STOPPED: begin
        go     = press;
        target = MODE_CLOSING;
      end
      MODE_ERROR: begin
        go     = press;
        target = MODE_START;
      end
      default: begin
        go = 1'b1;
        if (closed_act) begin
          target = MODE_CLOSED;
        end else if (open_act) begin
          target = MODE_OPEN;
        end else begin
          target = MODE_STOPPED;
        end
      end
    endcase
  end

  always_comb begin
    nxt             = cur;
    nxt.button_prev = smp.button_level;
    nxt.tick_count  = cnt;
    // Blink on tick for the mode held on arrival
    if (smp.tick) begin
      case (cur.mode)
        MODE_OPENING: nxt.red_lamp = ~cur.red_lamp;
        MODE_CLOSING: nxt.green_lamp = ~cur.green_lamp;
        MODE_PAUSE_OPEN, MODE_PAUSE_CLOSE: begin
          nxt.red_lamp   = ~cur.red_lamp;
          nxt.green_lamp = ~cur.green_lamp;
        end
        default: ;
      endcase
    end
    if (go) begin
      nxt.mode       = target;
      nxt.tick_count = '0;
      case (target)
        MODE_CLOSED:      {nxt.green_lamp, nxt.red_lamp} = 2'b10;
        MODE_OPENING:     {nxt.green_lamp, nxt.red_lamp} = 2'b10;
        MODE_OPEN:        {nxt.green_lamp, nxt.red_lamp} = 2'b01;
        MODE_CLOSING:     {nxt.green_lamp, nxt.red_lamp} = 2'b01;
        MODE_PAUSE_OPEN:  {nxt.green_lamp, nxt.red_lamp} = 2'b01;
        MODE_PAUSE_CLOSE: {nxt.green_lamp, nxt.red_lamp} = 2'b11;
        MODE_STOPPED:     {nxt.green_lamp, nxt.red_lamp} = 2'b00;
        MODE_ERROR:       {nxt.green_lamp, nxt.red_lamp} = 2'b11;
        default: ;  // start keeps the lamps
      endcase
    end
  end

  always_comb begin
    res.motor_run    = (nxt.mode == MODE_OPENING) || (nxt.mode == MODE_CLOSING);
    res.green_led    = nxt.green_lamp;
    res.red_led      = nxt.red_lamp;
    res.door_state   = nxt.mode;
    res.status_valid = status_valid;
    res.status_code  = status_valid ? status_code : STAT_CLOSED;
  end

endmodule

`default_nettype wire

/* tb/tb_door_motor_controller.sv */
`default_nettype none

module tb_door_motor_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import dmc_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dmc_in_if sample_bus ();
  dmc_out_if result_bus ();

  door_motor_controller dut (
    .clk       (clk),
    .rst       (rst),
    .sample    (sample_bus),
    .result    (result_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Random idling on both channels; clear it for a stretch of full-rate traffic.
  bit gaps_on = 1'b1;
  int unsigned mismatch_count = 0;

  // Results still owed by the block, oldest first.
  result_t door_results_due[$];

  // Shadow of the door controller: limits, door mode, tick counter, lamps and
  // the last button level seen.
  logic [TickW-1:0] stuck_lim;
  logic [TickW-1:0] travel_lim;
  logic [TickW-1:0] pause_lim;
  mode_t door_mode_q;
  logic [TickW-1:0] tick_cnt;
  logic green_q;
  logic red_q;
  logic btn_prev_q;

  // Button level held between random words, so presses come as real edges.
  logic btn_hold = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Generous ceiling on the whole run.
  initial begin
    #1_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Door predictor
  // ---------------------------------------------------------------------------

  function automatic void reset_door_shadow();
    stuck_lim   = StuckCheckReset;
    travel_lim  = TravelTimeoutReset;
    pause_lim   = PauseTimeoutReset;
    door_mode_q = MODE_START;
    tick_cnt    = '0;
    green_q     = 1'b0;
    red_q       = 1'b0;
    btn_prev_q  = 1'b1;
  endfunction

  // Entering a mode clears the tick counter and sets that mode's lamps;
  // start mode keeps whatever lamps were lit.
  function automatic void enter_door_mode(input mode_t m);
    door_mode_q = m;
    tick_cnt    = '0;
    case (m)
      MODE_CLOSED, MODE_OPENING: {green_q, red_q} = 2'b10;
      MODE_OPEN, MODE_CLOSING, MODE_PAUSE_OPEN: {green_q, red_q} = 2'b01;
      MODE_PAUSE_CLOSE, MODE_ERROR: {green_q, red_q} = 2'b11;
      MODE_STOPPED: {green_q, red_q} = 2'b00;
      default: ;
    endcase
  endfunction

  // Advance the shadow by one pin sample and return the word the block owes.
  function automatic result_t predict_door_step(input sample_t s);
    result_t r;
    mode_t m;
    logic press;
    logic closed_on;
    logic open_on;
    press      = btn_prev_q && !s.button_level;
    closed_on  = !s.closed_sensor;
    open_on    = !s.open_sensor;
    m          = door_mode_q;
    btn_prev_q = s.button_level;
    r          = '0;

    // Status reflects the mode held when the word arrived; start mode is silent.
    if (s.status_query && m != MODE_START) begin
      r.status_valid = 1'b1;
      case (m)
        MODE_CLOSED:  r.status_code = STAT_CLOSED;
        MODE_OPENING: r.status_code = STAT_OPENING;
        MODE_OPEN:    r.status_code = STAT_OPEN;
        MODE_CLOSING: r.status_code = STAT_CLOSING;
        MODE_PAUSE_OPEN, MODE_PAUSE_CLOSE, MODE_STOPPED: r.status_code = STAT_STOPPED;
        default:      r.status_code = STAT_ERROR;
      endcase
    end

    // Blink on the tick, then count it, holding at the top.
    if (s.tick) begin
      case (m)
        MODE_OPENING: red_q = ~red_q;
        MODE_CLOSING: green_q = ~green_q;
        MODE_PAUSE_OPEN, MODE_PAUSE_CLOSE: begin
          red_q   = ~red_q;
          green_q = ~green_q;
        end
        default: ;
      endcase
      if (tick_cnt != TickMax) tick_cnt = tick_cnt + 1'b1;
    end

    case (m)
      MODE_CLOSED: if (press) enter_door_mode(MODE_OPENING);
      MODE_OPENING: begin
        if (press) enter_door_mode(MODE_PAUSE_OPEN);
        else if (open_on) enter_door_mode(MODE_OPEN);
        else if (tick_cnt >= travel_lim) enter_door_mode(MODE_ERROR);
        else if (tick_cnt > stuck_lim && closed_on) enter_door_mode(MODE_ERROR);
      end
      MODE_OPEN: if (press || tick_cnt >= pause_lim) enter_door_mode(MODE_CLOSING);
      MODE_CLOSING: begin
        if (press) enter_door_mode(MODE_PAUSE_CLOSE);
        else if (closed_on) enter_door_mode(MODE_CLOSED);
        else if (tick_cnt >= travel_lim) enter_door_mode(MODE_ERROR);
        else if (tick_cnt > stuck_lim && open_on) enter_door_mode(MODE_ERROR);
      end
      MODE_PAUSE_OPEN: begin
        if (press) enter_door_mode(MODE_STOPPED);
        else if (tick_cnt >= pause_lim) enter_door_mode(MODE_CLOSING);
      end
      MODE_PAUSE_CLOSE: begin
        if (press) enter_door_mode(MODE_STOPPED);
        else if (tick_cnt >= pause_lim) enter_door_mode(MODE_OPENING);
      end
      MODE_STOPPED: if (press) enter_door_mode(MODE_CLOSING);
      MODE_ERROR: if (press) enter_door_mode(MODE_START);
      default: begin
        // Start mode settles on the very next word, taking the lamps of the mode it enters.
        if (closed_on) enter_door_mode(MODE_CLOSED);
        else if (open_on) enter_door_mode(MODE_OPEN);
        else enter_door_mode(MODE_STOPPED);
      end
    endcase

    r.motor_run  = (door_mode_q == MODE_OPENING) || (door_mode_q == MODE_CLOSING);
    r.green_led  = green_q;
    r.red_led    = red_q;
    r.door_state = door_mode_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Randomly stall the result side; never stall in the full-rate stretch.
  always @(negedge clk) begin
    result_bus.ready <= !rst && (!gaps_on || $urandom_range(99) >= 27);
  end

  // Compare every accepted result word with the oldest owed one.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (door_results_due.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result word with nothing expected, got state %0d",
                 $time, result_bus.door_state);
      end else begin
        want = door_results_due.pop_front();
        check_field("motor_run", want.motor_run, result_bus.motor_run);
        check_field("green_led", want.green_led, result_bus.green_led);
        check_field("red_led", want.red_led, result_bus.red_led);
        check_field("door_state", want.door_state, result_bus.door_state);
        check_field("status_valid", want.status_valid, result_bus.status_valid);
        check_field("status_code", want.status_code, result_bus.status_code);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (all entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  // Offer one pin word, wait for the handshake, and record what it must produce.
  task automatic send_word(input sample_t s);
    while (gaps_on && $urandom_range(99) < 27) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid         <= 1'b1;
    sample_bus.button_level  <= s.button_level;
    sample_bus.closed_sensor <= s.closed_sensor;
    sample_bus.open_sensor   <= s.open_sensor;
    sample_bus.tick          <= s.tick;
    sample_bus.status_query  <= s.status_query;
    do @(posedge clk); while (!sample_bus.ready);
    door_results_due.push_back(predict_door_step(s));
    @(negedge clk);
  endtask

  // Drop valid and hold off until every owed word is back, then let the bus sit idle.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    while (door_results_due.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three limits back to back; the block must be idle.
  task automatic load_limits(input logic [TickW-1:0] stuck, input logic [TickW-1:0] travel,
                             input logic [TickW-1:0] pause);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STUCK_CHECK;
    cfg_data  <= stuck;
    @(negedge clk);
    cfg_index <= REG_TRAVEL_TIMEOUT;
    cfg_data  <= travel;
    @(negedge clk);
    cfg_index <= REG_PAUSE_TIMEOUT;
    cfg_data  <= pause;
    @(negedge clk);
    cfg_we     <= 1'b0;
    stuck_lim  = stuck;
    travel_lim = travel;
    pause_lim  = pause;
  endtask

  function automatic sample_t pin_word(input logic btn, input logic closed_pin,
                                       input logic open_pin, input logic tk,
                                       input logic query);
    sample_t s;
    s.button_level  = btn;
    s.closed_sensor = closed_pin;
    s.open_sensor   = open_pin;
    s.tick          = tk;
    s.status_query  = query;
    return s;
  endfunction

  // Mostly plausible pin traffic: the button changes now and then, limit
  // sensors fire rarely, ticks are frequent. A slice of words is pure noise.
  function automatic sample_t roll_sample();
    sample_t s;
    logic [4:0] noise;
    if ($urandom_range(99) < 12) begin
      noise = 5'($urandom_range(31));
      s = noise;
    end else begin
      if ($urandom_range(99) < 15) btn_hold = ~btn_hold;
      s.button_level  = btn_hold;
      s.closed_sensor = ($urandom_range(99) >= 8);
      s.open_sensor   = ($urandom_range(99) >= 8);
      s.tick          = 1'($urandom_range(1));
      s.status_query  = ($urandom_range(99) < 20);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk every mode with short limits and leave each one at least once.
  task automatic test_directed_walk();
    load_limits(8'd1, 8'd4, 8'd2);
    send_word(pin_word(1, 0, 1, 0, 1)); // query in start: no reply; settle closed
    send_word(pin_word(1, 0, 1, 0, 1)); // query while closed
    send_word(pin_word(0, 0, 1, 1, 0)); // press: start opening
    send_word(pin_word(0, 0, 1, 1, 1)); // held button is no new press
    send_word(pin_word(1, 0, 1, 1, 0)); // closed sensor still on past stuck limit
    send_word(pin_word(0, 1, 1, 0, 1)); // query in error, press back to start
    send_word(pin_word(1, 1, 1, 0, 0)); // no sensor: stopped
    send_word(pin_word(0, 1, 1, 0, 1)); // press from stopped: closing
    send_word(pin_word(1, 1, 1, 1, 0));
    send_word(pin_word(0, 1, 1, 1, 0)); // press: pause while closing
    send_word(pin_word(1, 1, 1, 1, 1)); // blink both lamps, query paused
    send_word(pin_word(1, 1, 1, 1, 0)); // pause timeout reverses to opening
    send_word(pin_word(1, 1, 0, 0, 0)); // open sensor: open
    send_word(pin_word(1, 1, 1, 1, 0));
    send_word(pin_word(1, 1, 1, 1, 0)); // open times out: closing
    send_word(pin_word(1, 1, 1, 1, 1));
    send_word(pin_word(1, 1, 1, 1, 0));
    send_word(pin_word(1, 1, 1, 1, 0));
    send_word(pin_word(1, 1, 1, 1, 0)); // travel timeout: error
    send_word(pin_word(0, 1, 1, 0, 0)); // press: start
    send_word(pin_word(1, 1, 0, 0, 0)); // settle open
    send_word(pin_word(0, 1, 1, 0, 0)); // press: closing
    send_word(pin_word(1, 0, 0, 0, 0)); // both sensors on: closed wins
    send_word(pin_word(0, 1, 1, 0, 0)); // press: opening
    send_word(pin_word(1, 1, 1, 0, 0));
    send_word(pin_word(0, 1, 1, 0, 0)); // press: pause while opening
    send_word(pin_word(1, 1, 1, 0, 0));
    send_word(pin_word(0, 1, 1, 0, 0)); // press: stopped
  endtask

  // Random pin traffic under one set of limits, with a full drain halfway.
  task automatic test_random_traffic(input logic [TickW-1:0] stuck,
                                     input logic [TickW-1:0] travel,
                                     input logic [TickW-1:0] pause, input int words);
    drain_results();
    load_limits(stuck, travel, pause);
    for (int i = 0; i < words; i++) begin
      if (i == words / 2) drain_results();
      send_word(roll_sample());
    end
  endtask

  // Full-rate traffic: no gaps on the input, no stalls on the result.
  task automatic test_back_to_back(input int words);
    drain_results();
    load_limits(8'd3, 8'd10, 8'd5);
    gaps_on = 1'b0;
    for (int i = 0; i < words; i++) send_word(roll_sample());
    gaps_on = 1'b1;
  endtask

  initial begin
    rst                      = 1'b1;
    cfg_we                   = 1'b0;
    cfg_index                = REG_STUCK_CHECK;
    cfg_data                 = '0;
    sample_bus.valid         = 1'b0;
    sample_bus.button_level  = 1'b1;
    sample_bus.closed_sensor = 1'b1;
    sample_bus.open_sensor   = 1'b1;
    sample_bus.tick          = 1'b0;
    sample_bus.status_query  = 1'b0;
    result_bus.ready         = 1'b0;
    reset_door_shadow();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_walk();
    test_random_traffic(StuckCheckReset, TravelTimeoutReset, PauseTimeoutReset, 110);
    test_random_traffic(8'd2, 8'd6, 8'd4, 120);
    test_random_traffic(8'd0, 8'd0, 8'd0, 80);
    test_random_traffic(8'd255, 8'd255, 8'd255, 80);
    test_back_to_back(120);

    // Let the last words drain, then let the clock run on before the verdict.
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && door_results_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
